FILE: rtl/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// Shared constants for the proximity interest filter: field widths, beat
// layout, request modes, priority levels, register indexes and reset radii.
// ----------------------------------------------------------------------------
package pif_pkg;

  localparam int CLIENTS        = 16;
  localparam int CLIENT_BITS    = 4;
  localparam int ENTITY_BITS    = 10;
  localparam int COORD_BITS     = 24;
  localparam int MODE_BITS      = 3;
  localparam int PRIO_BITS      = 3;

  localparam int WORD_BITS      = 64;
  localparam int WORD_SEL_BITS  = 6;
  localparam int ROW_SEL_BITS   = ENTITY_BITS - WORD_SEL_BITS;
  localparam int ROW_BITS       = CLIENT_BITS + ROW_SEL_BITS;
  localparam int ROWS           = 1 << ROW_BITS;

  localparam int MAG_BITS       = COORD_BITS + 1;
  localparam int DIST_BITS      = 2 * MAG_BITS;
  localparam int RADIUS_BITS    = 50;

  // s_tdata layout
  localparam int IN_CID_LSB     = 0;
  localparam int IN_EID_LSB     = IN_CID_LSB + CLIENT_BITS;
  localparam int IN_X_LSB       = IN_EID_LSB + ENTITY_BITS;
  localparam int IN_Y_LSB       = IN_X_LSB + COORD_BITS;
  localparam int IN_Z_LSB       = IN_Y_LSB + COORD_BITS;
  localparam int IN_FIELD_BITS  = IN_Z_LSB + COORD_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

  // m_tdata layout
  localparam int OUT_HIT_LSB    = 0;
  localparam int OUT_PRIO_LSB   = 1;
  localparam int OUT_KNOWN_LSB  = OUT_PRIO_LSB + PRIO_BITS;
  localparam int OUT_FIELD_BITS = OUT_KNOWN_LSB + 1;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [MODE_BITS-1:0] MODE_UPDATE   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE   = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_HYST     = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_PRIORITY = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_PLAIN    = 3'd4;

  localparam logic [PRIO_BITS-1:0] PRIO_CRITICAL   = 3'd0;
  localparam logic [PRIO_BITS-1:0] PRIO_HIGH       = 3'd1;
  localparam logic [PRIO_BITS-1:0] PRIO_MEDIUM     = 3'd2;
  localparam logic [PRIO_BITS-1:0] PRIO_LOW        = 3'd3;
  localparam logic [PRIO_BITS-1:0] PRIO_BACKGROUND = 3'd4;

  localparam int CFG_ADDR_BITS = 3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INTEREST = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HYST     = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CRITICAL = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH     = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MEDIUM   = 3'd4;

  localparam logic [RADIUS_BITS-1:0] INTEREST_RESET = 50'd2621440000;
  localparam logic [RADIUS_BITS-1:0] HYST_RESET     = 50'd3171942400;
  localparam logic [RADIUS_BITS-1:0] CRITICAL_RESET = 50'd40960000;
  localparam logic [RADIUS_BITS-1:0] HIGH_RESET     = 50'd163840000;
  localparam logic [RADIUS_BITS-1:0] MEDIUM_RESET   = 50'd655360000;

endpackage

FILE: rtl/pif_ram.sv
// ----------------------------------------------------------------------------
// pif_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pif_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/proximity_interest_filter_top.sv
// ----------------------------------------------------------------------------
// proximity_interest_filter_top
// Area-of-interest distance filter: client position table, per-client
// visibility bitmap, squared 3D distance on one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: the shared multiplier makes three passes (x, y, z), the squares
//   are summed, and the bitmap read-modify-write and result beat close in the
//   last step, which waits on a held output beat; s_tready is high only in idle.
// Reset (rst, synchronous): clears client valid bits, bitmap row valid bits
//   and the output valid, and loads default radii. No clearing pass.
// ----------------------------------------------------------------------------
module proximity_interest_filter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // client_id, entity_id, pos_x, pos_y, pos_z, zero pad
  input  logic [pif_pkg::IN_TDATA_BITS-1:0]    s_tdata,
  // mode
  input  logic [pif_pkg::MODE_BITS-1:0]        s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // in_interest, priority_res, client_known, zero pad
  output logic [pif_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
  input  logic                                 cfg_we,
  input  logic [pif_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [pif_pkg::RADIUS_BITS-1:0]      cfg_data
);
  import pif_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQ_X = 6'b000010,
    ST_SQ_Y = 6'b000100,
    ST_SQ_Z = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_EVAL = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [RADIUS_BITS-1:0] interest_r, hyst_r, critical_r, high_r, medium_r;

  logic [CLIENTS-1:0]                client_valid;
  logic signed [COORD_BITS-1:0]      cpos_x [CLIENTS];
  logic signed [COORD_BITS-1:0]      cpos_y [CLIENTS];
  logic signed [COORD_BITS-1:0]      cpos_z [CLIENTS];
  logic [ROWS-1:0]                   row_valid;

  logic [MODE_BITS-1:0]              mode_q;
  logic [CLIENT_BITS-1:0]            cid_q;
  logic [ENTITY_BITS-1:0]            eid_q;
  logic signed [COORD_BITS-1:0]      px_q, py_q, pz_q;
  logic                              known_q;

  logic signed [COORD_BITS-1:0]      op_c, op_p;
  logic signed [COORD_BITS:0]        diff;
  logic [MAG_BITS-1:0]               mag;
  logic [DIST_BITS-1:0]              sq, prod, acc;

  logic                              s_fire, eval_go;
  logic [CLIENT_BITS-1:0]            s_cid;
  logic [ROW_BITS-1:0]               row_addr;
  logic [WORD_BITS-1:0]              ram_rdata, word_cur, bit_mask, ram_wdata;
  logic                              ram_we, marked;
  logic                              in_int, in_hyst, in_crit, in_high, in_med;
  logic                              hit;
  logic [PRIO_BITS-1:0]              prio;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign eval_go  = (state == ST_EVAL) && (!m_tvalid || m_tready);
  assign s_cid    = s_tdata[IN_CID_LSB +: CLIENT_BITS];

  // shared squaring unit
  always_comb begin
    op_c = cpos_x[cid_q];
    op_p = px_q;
    if (state == ST_SQ_Y) begin
      op_c = cpos_y[cid_q];
      op_p = py_q;
    end else if (state == ST_SQ_Z) begin
      op_c = cpos_z[cid_q];
      op_p = pz_q;
    end
  end

  assign diff = {op_c[COORD_BITS-1], op_c} - {op_p[COORD_BITS-1], op_p};
  assign mag  = diff[COORD_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
  assign sq   = DIST_BITS'(mag) * DIST_BITS'(mag);

  // sum of three squares stays below 2^DIST_BITS
  assign in_int  = (acc <= interest_r);
  assign in_hyst = (acc <= hyst_r);
  assign in_crit = (acc <= critical_r);
  assign in_high = (acc <= high_r);
  assign in_med  = (acc <= medium_r);

  // visibility bitmap
  assign row_addr = {cid_q, eid_q[ENTITY_BITS-1:WORD_SEL_BITS]};
  assign word_cur = row_valid[row_addr] ? ram_rdata : '0;
  assign bit_mask = WORD_BITS'(1) << eid_q[WORD_SEL_BITS-1:0];
  assign marked   = |(word_cur & bit_mask);
  assign ram_wdata = in_int ? (word_cur | bit_mask) : (word_cur & ~bit_mask);
  assign ram_we   = eval_go && (mode_q == MODE_HYST) && known_q &&
                    (in_int || (marked && !in_hyst));

  pif_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (ROWS)
  ) u_vis_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_addr),
    .wdata (ram_wdata),
    .re    (s_fire),
    .raddr ({s_cid, s_tdata[IN_EID_LSB + WORD_SEL_BITS +: ROW_SEL_BITS]}),
    .rdata (ram_rdata)
  );

  always_comb begin
    hit  = 1'b0;
    prio = PRIO_BACKGROUND;
    if (known_q) begin
      if (mode_q == MODE_PLAIN) begin
        hit = in_int;
      end else if (mode_q == MODE_HYST) begin
        hit = in_int || (marked && in_hyst);
      end else if (mode_q == MODE_PRIORITY) begin
        priority if (in_crit) prio = PRIO_CRITICAL;
        else if (in_high)     prio = PRIO_HIGH;
        else if (in_med)      prio = PRIO_MEDIUM;
        else if (in_int)      prio = PRIO_LOW;
        else                  prio = PRIO_BACKGROUND;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_fire) state_next = ST_SQ_X;
      end
      ST_SQ_X: state_next = ST_SQ_Y;
      ST_SQ_Y: state_next = ST_SQ_Z;
      ST_SQ_Z: state_next = ST_SUM;
      ST_SUM:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (eval_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      m_tvalid     <= 1'b0;
      client_valid <= '0;
      row_valid    <= '0;
      interest_r   <= INTEREST_RESET;
      hyst_r       <= HYST_RESET;
      critical_r   <= CRITICAL_RESET;
      high_r       <= HIGH_RESET;
      medium_r     <= MEDIUM_RESET;
    end else begin
      state <= state_next;
      if (eval_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_INTEREST: interest_r <= cfg_data;
          REG_HYST:     hyst_r     <= cfg_data;
          REG_CRITICAL: critical_r <= cfg_data;
          REG_HIGH:     high_r     <= cfg_data;
          REG_MEDIUM:   medium_r   <= cfg_data;
          default: ;
        endcase
      end
      if (eval_go && (mode_q == MODE_UPDATE)) begin
        client_valid[cid_q] <= 1'b1;
      end
      if (eval_go && (mode_q == MODE_REMOVE)) begin
        client_valid[cid_q] <= 1'b0;
        for (int r = 0; r < ROWS; r++) begin
          if (ROW_BITS'(r) >> ROW_SEL_BITS == ROW_BITS'(cid_q)) begin
            row_valid[r] <= 1'b0;
          end
        end
      end
      if (ram_we) begin
        row_valid[row_addr] <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (s_fire) begin
      mode_q  <= s_tuser;
      cid_q   <= s_cid;
      eid_q   <= s_tdata[IN_EID_LSB +: ENTITY_BITS];
      px_q    <= s_tdata[IN_X_LSB +: COORD_BITS];
      py_q    <= s_tdata[IN_Y_LSB +: COORD_BITS];
      pz_q    <= s_tdata[IN_Z_LSB +: COORD_BITS];
      known_q <= client_valid[s_cid];
    end
    if (state == ST_SQ_X) begin
      prod <= sq;
    end
    if (state == ST_SQ_Y) begin
      acc  <= prod;
      prod <= sq;
    end
    if (state == ST_SQ_Z) begin
      acc  <= acc + prod;
      prod <= sq;
    end
    if (state == ST_SUM) begin
      acc <= acc + prod;
    end
    if (eval_go && (mode_q == MODE_UPDATE)) begin
      cpos_x[cid_q] <= px_q;
      cpos_y[cid_q] <= py_q;
      cpos_z[cid_q] <= pz_q;
    end
    if (eval_go) begin
      m_tdata <= {(OUT_TDATA_BITS - OUT_FIELD_BITS)'(0), known_q, prio, hit};
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_PRIO_LSB +: PRIO_BITS] != PRIO_BACKGROUND)
      |-> m_tdata[OUT_KNOWN_LSB])
    else $error("priority level given for unknown client");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_HIT_LSB] |-> m_tdata[OUT_KNOWN_LSB])
    else $error("interest reported for unknown client");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_HIT_LSB]
      |-> (m_tdata[OUT_PRIO_LSB +: PRIO_BITS] == PRIO_BACKGROUND))
    else $error("interest and priority in one beat");

  assert property (@(posedge clk) disable iff (rst)
    eval_go && (mode_q == MODE_REMOVE) |=> !client_valid[$past(cid_q)])
    else $error("removed client still valid");

  assert property (@(posedge clk) disable iff (rst)
    s_fire |=> ##4 (state == ST_EVAL))
    else $error("sequencer out of step");

endmodule

FILE: tb/proximity_interest_filter_top_tb.sv
// ----------------------------------------------------------------------------
// proximity_interest_filter_top_tb
// Self-checking bench for the proximity interest filter. Requests go in as
// stream beats and every result beat is checked against an in-bench copy of
// the client table, visibility bitmaps and radii. Directed cases cover
// range boundaries, hysteresis marking, unknown clients, client removal and
// spare modes. Register extremes and output back-pressure follow, then
// random traffic under several radius settings with random idling both sides.
// ----------------------------------------------------------------------------
module proximity_interest_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pif_pkg::*;

  localparam int ENTITIES      = 1 << ENTITY_BITS;
  localparam int NUM_RADII     = 5;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RX_LONG_HOLD  = 200;
  localparam int STALL_LIMIT   = 4000;
  localparam int TRACKED       = 8;

  localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

  localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = {RADIUS_BITS{1'b1}};

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef longint unsigned dist_t;

  typedef struct {
    logic [MODE_BITS-1:0]   mode;
    logic [CLIENT_BITS-1:0] cid;
    logic [ENTITY_BITS-1:0] eid;
    coord_t                 x;
    coord_t                 y;
    coord_t                 z;
  } request_t;

  typedef struct packed {
    logic                 hit;
    logic [PRIO_BITS-1:0] prio;
    logic                 known;
  } result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
  logic [MODE_BITS-1:0]      s_tuser = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
  logic [RADIUS_BITS-1:0]    cfg_data = '0;

  // bench copy of the block state
  logic                   known_clients [CLIENTS];
  coord_t                 client_x [CLIENTS];
  coord_t                 client_y [CLIENTS];
  coord_t                 client_z [CLIENTS];
  logic [ENTITIES-1:0]    visible_map [CLIENTS];
  logic [RADIUS_BITS-1:0] radius_limit [NUM_RADII];
  int unsigned            radius_mag [NUM_RADII];

  result_t                pending_results [$];
  logic [ENTITY_BITS-1:0] tracked_entities [TRACKED];
  int unsigned            failures = 0;
  int unsigned            tx_gap_pct = 0;
  int unsigned            rx_stall_pct = 0;
  bit                     rx_hold_request = 1'b0;

  always #5 clk = ~clk;

  proximity_interest_filter_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic request_t req(logic [MODE_BITS-1:0] mode, int cid, int eid,
                                   int x, int y, int z);
    request_t rq;
    rq.mode = mode;
    rq.cid  = cid[CLIENT_BITS-1:0];
    rq.eid  = eid[ENTITY_BITS-1:0];
    rq.x    = coord_t'(x);
    rq.y    = coord_t'(y);
    rq.z    = coord_t'(z);
    return rq;
  endfunction

  function automatic dist_t sq_dist(logic [CLIENT_BITS-1:0] cid, coord_t x, coord_t y,
                                    coord_t z);
    longint dx;
    longint dy;
    longint dz;
    dx = longint'(signed'(client_x[cid])) - longint'(signed'(x));
    dy = longint'(signed'(client_y[cid])) - longint'(signed'(y));
    dz = longint'(signed'(client_z[cid])) - longint'(signed'(z));
    return dx * dx + dy * dy + dz * dz;
  endfunction

  // works out the result beat and advances the bench copy of the state
  function automatic result_t predict_result(request_t rq);
    result_t res;
    dist_t   range_sq;
    res.hit   = 1'b0;
    res.prio  = PRIO_BACKGROUND;
    res.known = known_clients[rq.cid];
    range_sq  = 0;
    if (res.known) range_sq = sq_dist(rq.cid, rq.x, rq.y, rq.z);
    case (rq.mode)
      MODE_UPDATE: begin
        client_x[rq.cid]      = rq.x;
        client_y[rq.cid]      = rq.y;
        client_z[rq.cid]      = rq.z;
        known_clients[rq.cid] = 1'b1;
      end
      MODE_REMOVE: begin
        known_clients[rq.cid] = 1'b0;
        visible_map[rq.cid]   = '0;
      end
      MODE_HYST: begin
        if (res.known) begin
          if (range_sq <= radius_limit[REG_INTEREST]) begin
            visible_map[rq.cid][rq.eid] = 1'b1;
            res.hit = 1'b1;
          end else if (visible_map[rq.cid][rq.eid]) begin
            if (range_sq <= radius_limit[REG_HYST]) res.hit = 1'b1;
            else visible_map[rq.cid][rq.eid] = 1'b0;
          end
        end
      end
      MODE_PRIORITY: begin
        if (res.known) begin
          if (range_sq <= radius_limit[REG_CRITICAL]) res.prio = PRIO_CRITICAL;
          else if (range_sq <= radius_limit[REG_HIGH]) res.prio = PRIO_HIGH;
          else if (range_sq <= radius_limit[REG_MEDIUM]) res.prio = PRIO_MEDIUM;
          else if (range_sq <= radius_limit[REG_INTEREST]) res.prio = PRIO_LOW;
        end
      end
      MODE_PLAIN: begin
        res.hit = res.known && (range_sq <= radius_limit[REG_INTEREST]);
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int near_origin();
    return int'($urandom_range(0, 2 ** 21)) - (2 ** 20);
  endfunction

  // mostly queries placed relative to a known client, often right on a radius
  function automatic request_t random_request();
    request_t    rq;
    int unsigned pick;
    int unsigned axis;
    int unsigned mag;
    int unsigned jit;
    int unsigned spread;
    int          off [3];
    pick   = $urandom_range(0, 99);
    rq.cid = CLIENT_BITS'($urandom_range(0, CLIENTS - 1));
    rq.eid = ENTITY_BITS'($urandom);
    if (pick < 12) rq.mode = MODE_UPDATE;
    else if (pick < 16) rq.mode = MODE_REMOVE;
    else if (pick < 45) rq.mode = MODE_HYST;
    else if (pick < 70) rq.mode = MODE_PRIORITY;
    else if (pick < 97) rq.mode = MODE_PLAIN;
    else rq.mode = MODE_BITS'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    if (rq.mode == MODE_HYST && $urandom_range(0, 3) != 0)
      rq.eid = tracked_entities[$urandom_range(0, TRACKED - 1)];
    if (rq.mode == MODE_UPDATE || !known_clients[rq.cid] || $urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        rq.x = coord_t'($urandom);
        rq.y = coord_t'($urandom);
        rq.z = coord_t'($urandom);
      end else begin
        rq.x = coord_t'(near_origin());
        rq.y = coord_t'(near_origin());
        rq.z = coord_t'(near_origin());
      end
    end else begin
      off = '{0, 0, 0};
      if ($urandom_range(0, 1) == 0) begin
        mag  = radius_mag[$urandom_range(0, NUM_RADII - 1)];
        jit  = mag / 32 + 2;
        axis = $urandom_range(0, 2);
        off[axis] = int'(mag + $urandom_range(0, 2 * jit)) - int'(jit);
        if ($urandom_range(0, 1) == 0) off[axis] = -off[axis];
      end else begin
        spread = $urandom_range(1, radius_mag[REG_HYST] + 1000);
        for (int a = 0; a < 3; a++)
          off[a] = int'($urandom_range(0, 2 * spread)) - int'(spread);
      end
      rq.x = coord_t'(int'(signed'(client_x[rq.cid])) + off[0]);
      rq.y = coord_t'(int'(signed'(client_y[rq.cid])) + off[1]);
      rq.z = coord_t'(int'(signed'(client_z[rq.cid])) + off[2]);
    end
    return rq;
  endfunction

  // one input beat; returns at the edge that takes it
  task automatic issue_request(request_t rq);
    result_t expected;
    @(negedge clk);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      s_tvalid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    s_tdata = '0;
    s_tdata[IN_CID_LSB +: CLIENT_BITS] = rq.cid;
    s_tdata[IN_EID_LSB +: ENTITY_BITS] = rq.eid;
    s_tdata[IN_X_LSB +: COORD_BITS]    = rq.x;
    s_tdata[IN_Y_LSB +: COORD_BITS]    = rq.y;
    s_tdata[IN_Z_LSB +: COORD_BITS]    = rq.z;
    s_tuser  = rq.mode;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    expected = predict_result(rq);
    pending_results = {pending_results, expected};
  endtask

  task automatic settle(int unsigned extra);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_radius(logic [CFG_ADDR_BITS-1:0] idx, logic [RADIUS_BITS-1:0] value,
                              int unsigned mag);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    radius_limit[idx] = value;
    radius_mag[idx]   = mag;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic restore_default_radii();
    write_radius(REG_INTEREST, INTEREST_RESET, 51200);
    write_radius(REG_HYST, HYST_RESET, 56320);
    write_radius(REG_CRITICAL, CRITICAL_RESET, 6400);
    write_radius(REG_HIGH, HIGH_RESET, 12800);
    write_radius(REG_MEDIUM, MEDIUM_RESET, 25600);
  endtask

  // ordered: critical <= high <= medium <= interest <= hysteresis
  task automatic randomize_radii(bit ordered);
    int unsigned mag [NUM_RADII];
    logic [CFG_ADDR_BITS-1:0] order [NUM_RADII];
    order = '{REG_CRITICAL, REG_HIGH, REG_MEDIUM, REG_INTEREST, REG_HYST};
    for (int i = 0; i < NUM_RADII; i++) begin
      if (ordered) mag[i] = (i == 0 ? 0 : mag[i-1]) + $urandom_range(0, 20000);
      else mag[i] = $urandom_range(0, 90000);
    end
    for (int i = 0; i < NUM_RADII; i++)
      write_radius(order[i], RADIUS_BITS'(longint'(mag[i]) * longint'(mag[i])), mag[i]);
  endtask

  task automatic test_directed_cases();
    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    issue_request(req(MODE_PLAIN, 0, 0, 0, 0, 0));           // unknown client
    issue_request(req(MODE_PRIORITY, 0, 1023, 0, 0, 0));
    issue_request(req(MODE_UPDATE, 0, 0, 0, 0, 0));          // creates the client
    issue_request(req(MODE_UPDATE, 0, 0, 0, 0, 0));
    issue_request(req(MODE_PLAIN, 0, 0, 51200, 0, 0));       // exactly on the radius
    issue_request(req(MODE_PLAIN, 0, 0, 51201, 0, 0));
    issue_request(req(MODE_PRIORITY, 0, 0, 6400, 0, 0));
    issue_request(req(MODE_PRIORITY, 0, 0, 6401, 0, 0));
    issue_request(req(MODE_PRIORITY, 0, 0, 0, -25600, 0));
    issue_request(req(MODE_PRIORITY, 0, 0, 0, 0, 51200));
    issue_request(req(MODE_PRIORITY, 0, 0, 0, 0, -51201));
    issue_request(req(MODE_HYST, 0, 1023, 0, 51200, 0));     // marks
    issue_request(req(MODE_HYST, 0, 1023, 0, 56320, 0));     // kept by hysteresis
    issue_request(req(MODE_HYST, 0, 1023, 0, 56321, 0));     // dropped
    issue_request(req(MODE_HYST, 0, 1023, 0, 56320, 0));     // no longer marked
    issue_request(req(MODE_UPDATE, 15, 0, -8388608, -8388608, -8388608));
    issue_request(req(MODE_PLAIN, 15, 1023, 8388607, 8388607, 8388607));
    issue_request(req(MODE_PRIORITY, 15, 0, 8388607, 8388607, 8388607));
    issue_request(req(MODE_SPARE_FIRST, 15, 0, 0, 0, 0));
    issue_request(req(MODE_SPARE_MID, 0, 0, 0, 0, 0));
    issue_request(req(MODE_SPARE_LAST, 0, 1023, 0, 0, 0));
    issue_request(req(MODE_HYST, 0, 0, -100, 0, 0));
    issue_request(req(MODE_REMOVE, 0, 0, 0, 0, 0));          // clears the bitmap too
    issue_request(req(MODE_PLAIN, 0, 0, 0, 0, 0));
    issue_request(req(MODE_UPDATE, 0, 0, 0, 0, 0));
    issue_request(req(MODE_HYST, 0, 0, 0, 56320, 0));
    settle(DRAIN_CYCLES);
  endtask

  task automatic test_radius_extremes();
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    for (int i = 0; i < NUM_RADII; i++) write_radius(CFG_ADDR_BITS'(i), '0, 0);
    issue_request(req(MODE_UPDATE, 7, 0, 1000, -2000, 3000));
    issue_request(req(MODE_PLAIN, 7, 0, 1000, -2000, 3000));
    issue_request(req(MODE_PLAIN, 7, 0, 1001, -2000, 3000));
    issue_request(req(MODE_PRIORITY, 7, 0, 1000, -2000, 3000));
    issue_request(req(MODE_HYST, 7, 512, 1000, -2000, 3000));
    issue_request(req(MODE_HYST, 7, 512, 1000, -2000, 3001));
    repeat (16) issue_request(random_request());
    settle(DRAIN_CYCLES);
    for (int i = 0; i < NUM_RADII; i++) write_radius(CFG_ADDR_BITS'(i), RADIUS_MAX, 1 << 25);
    issue_request(req(MODE_PLAIN, 15, 0, 8388607, 8388607, 8388607));
    issue_request(req(MODE_PRIORITY, 15, 0, 8388607, 8388607, 8388607));
    repeat (16) issue_request(random_request());
    settle(DRAIN_CYCLES);
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_output_backpressure();
    restore_default_radii();
    tx_gap_pct      = 0;
    rx_stall_pct    = 0;
    rx_hold_request = 1'b1;
    repeat (24) issue_request(random_request());
    settle(DRAIN_CYCLES);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          restore_default_radii();
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        1: begin
          randomize_radii(1'b1);
          tx_gap_pct   = 25;
          rx_stall_pct = 25;
        end
        2: begin
          randomize_radii(1'b0);
          tx_gap_pct   = 10;
          rx_stall_pct = 50;
        end
        default: begin
          randomize_radii(1'b1);
          tx_gap_pct   = 50;
          rx_stall_pct = 10;
        end
      endcase
      for (int i = 0; i < TRACKED; i++) tracked_entities[i] = ENTITY_BITS'($urandom);
      for (int c = 0; c < CLIENTS; c++)
        issue_request(req(MODE_UPDATE, c, 0, near_origin(), near_origin(), near_origin()));
      for (int n = 0; n < 120; n++) begin
        if (n % 50 == 49) settle(0);
        issue_request(random_request());
      end
      settle(DRAIN_CYCLES);
    end
  endtask

  // result side: random back-pressure plus one long hold on request
  initial begin : result_sink
    int unsigned hold_count;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_request) begin
        m_tready = 1'b0;
        for (hold_count = 0; hold_count < RX_LONG_HOLD; hold_count++) @(negedge clk);
        rx_hold_request = 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        m_tready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    logic                 got_hit;
    logic [PRIO_BITS-1:0] got_prio;
    logic                 got_known;
    if (!rst && m_tvalid && m_tready) begin
      got_hit   = m_tdata[OUT_HIT_LSB];
      got_prio  = m_tdata[OUT_PRIO_LSB +: PRIO_BITS];
      got_known = m_tdata[OUT_KNOWN_LSB];
      if (pending_results.size() == 0) begin
        $error("result beat with no request outstanding");
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (got_hit !== want.hit) begin
          $error("in_interest: expected %0d, got %0d", want.hit, got_hit);
          failures++;
        end
        if (got_prio !== want.prio) begin
          $error("priority_res: expected %0d, got %0d", want.prio, got_prio);
          failures++;
        end
        if (got_known !== want.known) begin
          $error("client_known: expected %0d, got %0d", want.known, got_known);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    for (int c = 0; c < CLIENTS; c++) begin
      known_clients[c] = 1'b0;
      client_x[c]      = '0;
      client_y[c]      = '0;
      client_z[c]      = '0;
      visible_map[c]   = '0;
    end
    radius_limit[REG_INTEREST] = INTEREST_RESET;
    radius_limit[REG_HYST]     = HYST_RESET;
    radius_limit[REG_CRITICAL] = CRITICAL_RESET;
    radius_limit[REG_HIGH]     = HIGH_RESET;
    radius_limit[REG_MEDIUM]   = MEDIUM_RESET;
    radius_mag = '{51200, 56320, 6400, 12800, 25600};
    for (int i = 0; i < TRACKED; i++) tracked_entities[i] = ENTITY_BITS'($urandom);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_radius_extremes();
    test_output_backpressure();
    test_random_traffic();

    settle(DRAIN_CYCLES);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: proximity_interest_filter_top.f
rtl/pif_pkg.sv
rtl/pif_ram.sv
rtl/proximity_interest_filter_top.sv
tb/proximity_interest_filter_top_tb.sv
